### hw/rtl/sstp_pkg.sv
// Shared types, constants and register indexes for the thermistor/pressure scan.
package sstp_pkg;

    localparam int unsigned ThermSamplesDef = 8;
    localparam int unsigned PressSamplesDef = 8;

    localparam int unsigned AdcFull     = 8191;
    localparam int unsigned KelvinCenti = 27315;
    localparam logic [29:0] Ln2Q30      = 30'd744261118;
    localparam int          ValMax      = 131071;
    localparam int          ValMin      = -131072;

    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned CfgDataW = 20;

    typedef enum logic [CfgAddrW-1:0] {
        REG_SERIES  = 3'd0,
        REG_NOMINAL = 3'd1,
        REG_BETA    = 3'd2,
        REG_NOMTEMP = 3'd3,
        REG_PFULL   = 3'd4,
        REG_PZERO   = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_LOW  = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    // Sequencer states of the conversion engine.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_NUM,
        S_LOG_NUM,
        S_MUL_DEN,
        S_LOG_DEN,
        S_MUL_LN2,
        S_DIV_BETA,
        S_DIV_NOM,
        S_DIV_T,
        S_PRESS_AVG,
        S_PRESS_MUL,
        S_PRESS_DIV,
        S_FINISH,
        S_OUT
    } t_state;

    // Request from the top level to the conversion engine.
    typedef struct packed {
        logic        start;
        logic        press;
        logic [19:0] sum;
    } t_conv_req;

endpackage

### hw/rtl/sstp_conv.sv
// Conversion engine: shift-add multiplier, restoring divider and squaring log2, all bit serial.
module sstp_conv #(
    parameter int unsigned THERM_SAMPLES = sstp_pkg::ThermSamplesDef,
    parameter int unsigned PRESSURE_SAMPLES = sstp_pkg::PressSamplesDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sstp_pkg::t_conv_req  i_req,
    input  logic [19:0]          i_rs,
    input  logic [19:0]          i_r0,
    input  logic [15:0]          i_beta,
    input  logic [13:0]          i_tnom,
    input  logic [15:0]          i_pfull,
    input  logic [15:0]          i_pzero,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [17:0]          o_value,
    output logic [1:0]           o_status
);
    localparam logic [19:0] FullT = 20'(sstp_pkg::AdcFull * THERM_SAMPLES);
    localparam logic [19:0] NT    = 20'(THERM_SAMPLES);

    sstp_pkg::t_state r_state, n_state;

    // shared shift-add multiplier (multiplicand up to 64 bits, multiplier up to 40)
    logic [63:0]  r_ma, n_ma;
    logic [39:0]  r_mb, n_mb;
    logic [79:0]  r_acc, n_acc;
    // restoring divider
    logic [79:0]  r_dq, n_dq;
    logic [63:0]  r_drem, n_drem;
    logic [63:0]  r_ddiv, n_ddiv;
    logic [6:0]   r_cnt, n_cnt;
    // log2 squaring unit
    logic [31:0]  r_m, n_m;
    logic [23:0]  r_frac, n_frac;
    logic [5:0]   r_exp, n_exp;
    logic [30:0]  r_lnum, n_lnum;
    logic         r_neg, n_neg;
    logic [63:0]  r_y, n_y;
    logic [17:0]  r_val, n_val;
    logic [1:0]   r_st, n_st;
    logic         r_press, n_press;
    logic [19:0]  r_sum, n_sum;

    logic [63:0]  w_sq;
    logic [64:0]  w_sub;
    logic [5:0]   w_lead;
    logic [63:0]  w_x;
    logic signed [64:0] w_t;
    logic signed [64:0] w_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sstp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_ma <= n_ma; r_mb <= n_mb; r_acc <= n_acc;
        r_dq <= n_dq; r_drem <= n_drem; r_ddiv <= n_ddiv; r_cnt <= n_cnt;
        r_m <= n_m; r_frac <= n_frac; r_exp <= n_exp; r_lnum <= n_lnum;
        r_neg <= n_neg; r_y <= n_y; r_val <= n_val; r_st <= n_st;
        r_press <= n_press; r_sum <= n_sum;
    end

    // squaring of Q1.30 mantissa: 31x31, within one multiplier
    assign w_sq  = 64'(r_m[30:0]) * 64'(r_m[30:0]);
    assign w_sub = {r_drem[62:0], r_dq[79]} - {1'b0, r_ddiv};
    assign w_x   = r_acc[63:0];

    always_comb begin
        w_lead = '0;
        for (int i = 0; i < 64; i++) begin
            if (w_x[i]) w_lead = 6'(i);
        end
    end

    assign w_t = $signed({1'b0, r_dq[63:0]}) - 65'sd27315;
    assign w_p = $signed({49'd0, i_pzero}) +
                 (r_neg ? -$signed({1'b0, r_dq[63:0]}) : $signed({1'b0, r_dq[63:0]}));

    always_comb begin
        n_state = r_state;
        n_ma = r_ma; n_mb = r_mb; n_acc = r_acc;
        n_dq = r_dq; n_drem = r_drem; n_ddiv = r_ddiv; n_cnt = r_cnt;
        n_m = r_m; n_frac = r_frac; n_exp = r_exp; n_lnum = r_lnum;
        n_neg = r_neg; n_y = r_y; n_val = r_val; n_st = r_st;
        n_press = r_press; n_sum = r_sum;
        o_done = 1'b0;
        unique case (r_state)
            sstp_pkg::S_IDLE: begin
                if (i_req.start) begin
                    n_press = i_req.press;
                    n_sum   = i_req.sum;
                    n_acc   = '0;
                    n_cnt   = '0;
                    if (i_req.press) begin
                        // floor average first, then the linear map
                        n_dq = 80'(i_req.sum);
                        n_drem = '0;
                        n_ddiv = 64'(PRESSURE_SAMPLES);
                        n_state = sstp_pkg::S_PRESS_AVG;
                    end else if (i_req.sum < NT) begin
                        n_val = 18'(-sstp_pkg::KelvinCenti);
                        n_st = sstp_pkg::ST_LOW;
                        n_state = sstp_pkg::S_OUT;
                    end else if (i_req.sum >= FullT || i_rs == '0 || i_r0 == '0 ||
                                 i_beta == '0) begin
                        n_val = 18'(-sstp_pkg::KelvinCenti);
                        n_st = sstp_pkg::ST_SAT;
                        n_state = sstp_pkg::S_OUT;
                    end else begin
                        n_ma = 64'(i_rs);
                        n_mb = 40'(i_req.sum);
                        n_state = sstp_pkg::S_MUL_NUM;
                    end
                end
            end
            sstp_pkg::S_MUL_NUM, sstp_pkg::S_MUL_DEN, sstp_pkg::S_PRESS_MUL: begin
                if (r_mb[0]) n_acc = r_acc + 80'(r_ma);
                n_ma = r_ma << 1;
                n_mb = r_mb >> 1;
                if (r_mb == '0) begin
                    n_cnt = '0;
                    unique case (r_state)
                        sstp_pkg::S_MUL_NUM, sstp_pkg::S_MUL_DEN: begin
                            n_exp = w_lead;
                            n_m = (w_lead >= 6'd30) ? 32'(w_x >> (w_lead - 6'd30))
                                                    : 32'(w_x << (6'd30 - w_lead));
                            n_frac = '0;
                            n_state = (r_state == sstp_pkg::S_MUL_NUM) ?
                                      sstp_pkg::S_LOG_NUM : sstp_pkg::S_LOG_DEN;
                        end
                        default: begin
                            // |prod| + 32764, divided by 65528
                            n_dq = 80'(r_acc[63:0] + 64'd32764);
                            n_drem = '0;
                            n_ddiv = 64'd65528;
                            n_state = sstp_pkg::S_PRESS_DIV;
                        end
                    endcase
                end
            end
            sstp_pkg::S_LOG_NUM, sstp_pkg::S_LOG_DEN: begin
                n_frac = {r_frac[22:0], 1'b0};
                n_m = w_sq[61:30];
                if (w_sq[61]) begin
                    n_m = 32'(w_sq[61:31]);
                    n_frac[0] = 1'b1;
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd23) begin
                    if (r_state == sstp_pkg::S_LOG_NUM) begin
                        n_lnum = {1'b0, r_exp, n_frac};
                        n_ma = 64'(i_r0);
                        n_mb = 40'(FullT - r_sum);
                        n_acc = '0;
                        n_state = sstp_pkg::S_MUL_DEN;
                    end else begin
                        logic signed [31:0] d;
                        d = $signed({1'b0, r_lnum}) - $signed({2'b0, r_exp, n_frac});
                        n_neg = d[31];
                        n_ma = 64'(d[31] ? -d : d);
                        n_mb = 40'(sstp_pkg::Ln2Q30);
                        n_acc = '0;
                        n_state = sstp_pkg::S_MUL_LN2;
                    end
                end
            end
            sstp_pkg::S_MUL_LN2: begin
                if (r_mb[0]) n_acc = r_acc + 80'(r_ma);
                n_ma = r_ma << 1;
                n_mb = r_mb >> 1;
                if (r_mb == '0) begin
                    n_dq = r_acc;
                    n_drem = '0;
                    n_ddiv = 64'({i_beta, 14'd0});
                    n_cnt = '0;
                    n_state = sstp_pkg::S_DIV_BETA;
                end
            end
            sstp_pkg::S_DIV_BETA, sstp_pkg::S_DIV_NOM, sstp_pkg::S_DIV_T,
            sstp_pkg::S_PRESS_AVG, sstp_pkg::S_PRESS_DIV: begin
                // one quotient bit a cycle
                n_dq = {r_dq[78:0], ~w_sub[64]};
                n_drem = w_sub[64] ? {r_drem[62:0], r_dq[79]} : w_sub[63:0];
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd79) begin
                    n_cnt = '0;
                    unique case (r_state)
                        sstp_pkg::S_DIV_BETA: begin
                            n_y = r_neg ? -n_dq[63:0] : n_dq[63:0];
                            n_dq = 80'(100) << 40;
                            n_drem = '0;
                            n_ddiv = 64'(i_tnom) + 64'(sstp_pkg::KelvinCenti);
                            n_state = sstp_pkg::S_DIV_NOM;
                        end
                        sstp_pkg::S_DIV_NOM: begin
                            logic [63:0] y;
                            y = r_y + n_dq[63:0];
                            n_y = y;
                            if (y[63] || y == '0) begin
                                n_val = 18'(sstp_pkg::ValMax);
                                n_st = sstp_pkg::ST_SAT;
                                n_state = sstp_pkg::S_OUT;
                            end else begin
                                n_dq = (80'(100) << 40) + 80'(y >> 1);
                                n_drem = '0;
                                n_ddiv = y;
                                n_state = sstp_pkg::S_DIV_T;
                            end
                        end
                        sstp_pkg::S_PRESS_AVG: begin
                            logic signed [17:0] span;
                            logic signed [19:0] x;
                            span = $signed({2'b0, i_pfull}) - $signed({2'b0, i_pzero});
                            x = $signed(20'(n_dq[12:0]) * 20'd10) - 20'sd8191;
                            n_neg = span[17] ^ x[19];
                            n_ma = 64'(span[17] ? -span : span);
                            n_mb = 40'(x[19] ? -x : x);
                            n_acc = '0;
                            n_state = sstp_pkg::S_PRESS_MUL;
                        end
                        default: n_state = sstp_pkg::S_FINISH;
                    endcase
                end
            end
            sstp_pkg::S_FINISH: begin
                n_state = sstp_pkg::S_OUT;
                n_st = sstp_pkg::ST_OK;
                if (r_press) begin
                    if (w_p > 65'sd131071) begin
                        n_val = 18'(sstp_pkg::ValMax); n_st = sstp_pkg::ST_SAT;
                    end else if (w_p < -65'sd131072) begin
                        n_val = 18'(sstp_pkg::ValMin); n_st = sstp_pkg::ST_SAT;
                    end else begin
                        n_val = w_p[17:0];
                    end
                end else if (w_t > 65'sd131071) begin
                    n_val = 18'(sstp_pkg::ValMax); n_st = sstp_pkg::ST_SAT;
                end else begin
                    n_val = w_t[17:0];
                end
            end
            sstp_pkg::S_OUT: begin
                o_done = 1'b1;
                n_state = sstp_pkg::S_IDLE;
            end
            default: n_state = sstp_pkg::S_IDLE;
        endcase
    end

    assign o_busy   = (r_state != sstp_pkg::S_IDLE);
    assign o_value  = r_val;
    assign o_status = r_st;
endmodule

### hw/rtl/sensor_scan_thermistor_pressure.sv
// Top level of the thermistor/pressure scan: sample averaging, slot sequencing, result register.
// Each ADC item is accepted with its handshake; the item that closes a slot starts the bit-serial
// conversion engine and the input stalls until it finishes. The conversion of a thermistor slot
// runs two shift-add multiplies, two 24-step log2 squarings, an ln2 multiply, three 80-step
// restoring divisions, a start, a finish and an output state; a pressure slot runs an 80-step
// averaging division, a multiply, an 80-step division, a start, a finish and an output state;
// an average below one or a rail or zero-register slot goes straight to the output state.
// The input is held off while the engine is busy.
// The result is held in an output register so the next slot's samples flow while it waits;
// only the item that closes the next slot waits for it to be taken.
module sensor_scan_thermistor_pressure #(
    parameter int unsigned THERM_SAMPLES = sstp_pkg::ThermSamplesDef,
    parameter int unsigned PRESSURE_SAMPLES = sstp_pkg::PressSamplesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [12:0] raw_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // slot_index, mux_number, channel_number,
                                        // sensor_kind, reading_value, reading_status
    output logic        m_axis_tlast,   // scan_done
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [sstp_pkg::CfgAddrW-1:0] i_cfg_index,
    input  logic [sstp_pkg::CfgDataW-1:0] i_cfg_data
);
    logic [19:0] r_rs, r_r0;
    logic [15:0] r_beta, r_pfull, r_pzero;
    logic [13:0] r_tnom;
    logic [4:0]  r_slot;
    logic [6:0]  r_cnt;
    logic [19:0] r_acc;
    logic [4:0]  r_cslot;
    logic        r_ovalid;
    logic [31:0] r_odata;
    logic        r_olast;

    sstp_pkg::t_conv_req r_req;
    logic        w_busy, w_done;
    logic [17:0] w_val;
    logic [1:0]  w_st;
    logic        w_acc_in, w_press, w_last;
    logic [19:0] w_sum;
    logic [6:0]  w_n;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !w_busy && !r_req.start && !(r_ovalid && w_last);
    assign w_acc_in = s_axis_tvalid && s_axis_tready;
    assign w_press  = (r_slot >= 5'd28);
    assign w_n      = w_press ? 7'(PRESSURE_SAMPLES) : 7'(THERM_SAMPLES);
    assign w_sum    = r_acc + 20'(s_axis_tdata[12:0]);
    assign w_last   = ((r_cnt + 7'd1) >= w_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs <= 20'd10000; r_r0 <= 20'd10000; r_beta <= 16'd3950;
            r_tnom <= 14'd2500; r_pfull <= 16'd10000; r_pzero <= '0;
            r_slot <= '0; r_cnt <= '0; r_acc <= '0; r_ovalid <= 1'b0;
            r_req <= '0;
        end else begin
            r_req.start <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sstp_pkg::REG_SERIES:  r_rs    <= i_cfg_data;
                    sstp_pkg::REG_NOMINAL: r_r0    <= i_cfg_data;
                    sstp_pkg::REG_BETA:    r_beta  <= i_cfg_data[15:0];
                    sstp_pkg::REG_NOMTEMP: r_tnom  <= i_cfg_data[13:0];
                    sstp_pkg::REG_PFULL:   r_pfull <= i_cfg_data[15:0];
                    sstp_pkg::REG_PZERO:   r_pzero <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (w_acc_in) begin
                if (w_last) begin
                    r_req.start <= 1'b1;
                    r_req.press <= w_press;
                    r_req.sum   <= w_sum;
                    r_cslot <= r_slot;
                    r_slot <= r_slot + 5'd1;
                    r_cnt <= '0;
                    r_acc <= '0;
                end else begin
                    r_cnt <= r_cnt + 7'd1;
                    r_acc <= w_sum;
                end
            end
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (w_done) begin
                r_ovalid <= 1'b1;
                r_odata  <= {1'b0, w_st, w_val, r_cslot >= 5'd28, ~r_cslot[3:0],
                             r_cslot[4], r_cslot};
                r_olast  <= (r_cslot == 5'd31);
            end
        end
    end

    sstp_conv #(
        .THERM_SAMPLES(THERM_SAMPLES),
        .PRESSURE_SAMPLES(PRESSURE_SAMPLES)
    ) u_conv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_req),
        .i_rs(r_rs), .i_r0(r_r0), .i_beta(r_beta), .i_tnom(r_tnom),
        .i_pfull(r_pfull), .i_pzero(r_pzero),
        .o_busy(w_busy), .o_done(w_done), .o_value(w_val), .o_status(w_st)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
endmodule

### hw/rtl/sstp_checker.sv
// Port-level checker for the thermistor/pressure scan and its bind.
module sstp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed under stall");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tlast == (m_axis_tdata[4:0] == 5'd31))
        else $error("tlast not on last slot");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[10] == (m_axis_tdata[4:2] == 3'b111))
        else $error("sensor kind mismatch");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[30:29] != 2'd3)
        else $error("bad status code");
endmodule

bind sensor_scan_thermistor_pressure sstp_checker u_chk (.*);

### bench/testbench.sv
// Self-checking bench for the thermistor/pressure scan block, with a bit-exact conversion predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HoldOffCycles = 3000;
    localparam int SettleCycles  = 600;
    localparam int WatchLimit    = 20000;

    typedef struct packed {
        logic              done;
        logic [1:0]        status;
        logic signed [17:0] value;
        logic              kind;
        logic [3:0]        channel;
        logic              mux;
        logic [4:0]        slot;
    } t_reading;

    typedef struct {
        sstp_pkg::t_reg_idx idx;
        logic [19:0]        data;
    } t_cfg_write;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [sstp_pkg::CfgAddrW-1:0] i_cfg_index = '0;
    logic [sstp_pkg::CfgDataW-1:0] i_cfg_data = '0;

    sensor_scan_thermistor_pressure uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor copy of registers and scan state
    logic [19:0] series_r, nominal_r;
    logic [15:0] beta_r, pfull_r, pzero_r;
    logic [13:0] nomtemp_r;
    logic [4:0]  cur_slot;
    logic [6:0]  sample_cnt;
    logic [19:0] sample_sum;

    logic [12:0]  sample_queue[$];
    t_cfg_write   cfg_queue[$];
    t_reading     readings_due[$];
    int  errors = 0;
    int  results_seen = 0;
    bit  calm = 0;
    int  idle_watch = 0;

    function automatic longint log2_q24(longint unsigned x);
        int e;
        longint unsigned m;
        longint fr;
        e = 63;
        fr = 0;
        while (e > 0 && x[e] == 1'b0) e--;
        m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                fr = fr | 1;
            end
        end
        return (longint'(e) << 24) + fr;
    endfunction

    function automatic longint therm_temp(longint unsigned s, output sstp_pkg::t_status st);
        longint unsigned full, num, den, one;
        longint d, a, y, t;
        full = 64'd8191 * 8;
        if (s < 8) begin
            st = sstp_pkg::ST_LOW;
            return -27315;
        end
        if (s >= full || series_r == 0 || nominal_r == 0 || beta_r == 0) begin
            st = sstp_pkg::ST_SAT;
            return -27315;
        end
        num = series_r * s;
        den = nominal_r * (full - s);
        d = log2_q24(num) - log2_q24(den);
        a = (d * 744261118) / (longint'(beta_r) << 14);
        one = 64'd100 << 40;
        y = a + longint'(one / (nomtemp_r + 64'd27315));
        if (y <= 0) begin
            st = sstp_pkg::ST_SAT;
            return 131071;
        end
        t = longint'((one + longint'(y) / 2) / longint'(y)) - 27315;
        if (t > 131071) begin
            st = sstp_pkg::ST_SAT;
            return 131071;
        end
        st = sstp_pkg::ST_OK;
        return t;
    endfunction

    function automatic longint pressure_level(longint unsigned s,
                                              output sstp_pkg::t_status st);
        longint avg, span, prod, mag, q, p;
        avg = s / 8;
        span = longint'(pfull_r) - longint'(pzero_r);
        prod = span * (10 * avg - 8191);
        mag = prod < 0 ? -prod : prod;
        q = (mag + 32764) / 65528;
        if (prod < 0) q = -q;
        p = longint'(pzero_r) + q;
        st = sstp_pkg::ST_OK;
        if (p > 131071) begin st = sstp_pkg::ST_SAT; p = 131071; end
        if (p < -131072) begin st = sstp_pkg::ST_SAT; p = -131072; end
        return p;
    endfunction

    // advance the scan by one sample; queue the reading when a slot closes
    function automatic void take_sample(logic [12:0] raw);
        t_reading r;
        sstp_pkg::t_status st;
        longint   v;
        bit       press;
        press = cur_slot >= 5'd28;
        sample_sum = sample_sum + 20'(raw);
        sample_cnt = sample_cnt + 7'd1;
        if (sample_cnt < 7'd8) return;
        v = press ? pressure_level(sample_sum, st) : therm_temp(sample_sum, st);
        r.slot = cur_slot;
        r.mux = cur_slot[4];
        r.channel = 4'd15 - cur_slot[3:0];
        r.kind = press;
        r.value = v[17:0];
        r.status = st;
        r.done = cur_slot == 5'd31;
        readings_due.push_back(r);
        sample_cnt = '0;
        sample_sum = '0;
        cur_slot = cur_slot + 5'd1;
    endfunction

    // sample driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        logic nv;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                take_sample(s_axis_tdata[12:0]);
                nv = 1'b0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (sample_queue.size() > 0) begin
                    s_axis_tdata <= {3'b0, sample_queue.pop_front()};
                    nv = 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0)
                        send_gap <= int'($urandom_range(1, 12));
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // register write driver
    always @(posedge i_clk) begin
        t_cfg_write w;
        logic nv;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            nv = i_cfg_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (sstp_pkg::t_reg_idx'(i_cfg_index))
                    sstp_pkg::REG_SERIES:  series_r  = i_cfg_data;
                    sstp_pkg::REG_NOMINAL: nominal_r = i_cfg_data;
                    sstp_pkg::REG_BETA:    beta_r    = i_cfg_data[15:0];
                    sstp_pkg::REG_NOMTEMP: nomtemp_r = i_cfg_data[13:0];
                    sstp_pkg::REG_PFULL:   pfull_r   = i_cfg_data[15:0];
                    sstp_pkg::REG_PZERO:   pzero_r   = i_cfg_data[15:0];
                    default: ;
                endcase
                nv = 1'b0;
            end
            if (!nv && cfg_queue.size() > 0) begin
                w = cfg_queue.pop_front();
                i_cfg_index <= w.idx;
                i_cfg_data <= w.data;
                nv = 1'b1;
            end
            i_cfg_valid <= nv;
        end
    end

    // result monitor and receiver stalls
    int stall = 0;
    always @(posedge i_clk) begin
        t_reading got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_reading'({m_axis_tlast, m_axis_tdata[30:0]});
                results_seen <= results_seen + 1;
                if (readings_due.size() == 0) begin
                    $error("unexpected reading %p", got);
                    errors++;
                end else begin
                    want = readings_due.pop_front();
                    if (got.slot !== want.slot) begin
                        $error("slot_index exp %0d got %0d", want.slot, got.slot); errors++;
                    end
                    if (got.mux !== want.mux) begin
                        $error("mux_number exp %0d got %0d", want.mux, got.mux); errors++;
                    end
                    if (got.channel !== want.channel) begin
                        $error("channel_number exp %0d got %0d", want.channel, got.channel);
                        errors++;
                    end
                    if (got.kind !== want.kind) begin
                        $error("sensor_kind exp %0d got %0d", want.kind, got.kind); errors++;
                    end
                    if (got.value !== want.value) begin
                        $error("reading_value exp %0d got %0d", want.value, got.value); errors++;
                    end
                    if (got.status !== want.status) begin
                        $error("reading_status exp %0d got %0d", want.status, got.status); errors++;
                    end
                    if (got.done !== want.done) begin
                        $error("scan_done exp %0d got %0d", want.done, got.done); errors++;
                    end
                end
            end
            if (results_seen == 40 && m_axis_tvalid && m_axis_tready) begin
                stall <= HoldOffCycles;  // long hold-off: input must back up
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall <= stall - 1;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall <= int'($urandom_range(1, 12));
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_watch <= 0;
        end else if (idle_watch >= WatchLimit) begin
            $display("sensor_scan_thermistor_pressure regression: fail");
            $finish;
        end else begin
            idle_watch <= idle_watch + 1;
        end
    end

    task automatic write_reg(sstp_pkg::t_reg_idx idx, logic [19:0] data);
        t_cfg_write w;
        w.idx = idx;
        w.data = data;
        cfg_queue.push_back(w);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (sample_queue.size() > 0 || s_axis_tvalid || readings_due.size() > 0 ||
               cfg_queue.size() > 0 || i_cfg_valid);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // one slot's worth of samples: half the time a noisy level, otherwise rails, near-rails or noise
    task automatic push_set();
        int base, mode, v;
        mode = $urandom_range(0, 9);
        base = $urandom_range(0, 8191);
        for (int i = 0; i < 8; i++) begin
            case (mode)
                0: v = 0;
                1: v = 8191;
                2: v = $urandom_range(0, 8191);
                3: v = (i == 0) ? $urandom_range(0, 7) : 0;
                4: v = (i == 0) ? 8190 : 8191;
                default: v = base + $urandom_range(0, 64) - 32;
            endcase
            if (v < 0) v = 0;
            if (v > 8191) v = 8191;
            sample_queue.push_back(13'(v));
        end
    endtask

    task automatic run_phase(int sets);
        for (int k = 0; k < sets; k++) push_set();
        drain();
    endtask

    initial begin
        series_r = 20'd10000; nominal_r = 20'd10000; beta_r = 16'd3950;
        nomtemp_r = 14'd2500; pfull_r = 16'd10000; pzero_r = '0;
        cur_slot = '0; sample_cnt = '0; sample_sum = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: rails, near-rails, single counts
        for (int i = 0; i < 8; i++) sample_queue.push_back(13'd0);
        for (int i = 0; i < 8; i++) sample_queue.push_back(13'd8191);
        for (int i = 0; i < 8; i++) sample_queue.push_back(i == 0 ? 13'd7 : 13'd0);
        for (int i = 0; i < 8; i++) sample_queue.push_back(i == 0 ? 13'd8184 : 13'd8191);
        drain();

        run_phase(34);
        write_reg(sstp_pkg::REG_SERIES, 20'd1);
        write_reg(sstp_pkg::REG_NOMINAL, 20'hFFFFF);
        write_reg(sstp_pkg::REG_BETA, 20'd1);
        write_reg(sstp_pkg::REG_NOMTEMP, 20'd0);
        write_reg(sstp_pkg::REG_PFULL, 20'hFFFF);
        write_reg(sstp_pkg::REG_PZERO, 20'd0);
        drain();
        run_phase(34);
        write_reg(sstp_pkg::REG_SERIES, 20'hFFFFF);
        write_reg(sstp_pkg::REG_NOMINAL, 20'd1);
        write_reg(sstp_pkg::REG_BETA, 20'hFFFF);
        write_reg(sstp_pkg::REG_NOMTEMP, 20'd15000);
        write_reg(sstp_pkg::REG_PFULL, 20'd0);
        write_reg(sstp_pkg::REG_PZERO, 20'hFFFF);
        drain();
        run_phase(34);
        write_reg(sstp_pkg::REG_SERIES, 20'd0);
        write_reg(sstp_pkg::REG_BETA, 20'd0);
        write_reg(sstp_pkg::REG_NOMTEMP, 20'h3FFF);
        drain();
        run_phase(20);
        for (int p = 0; p < 3; p++) begin
            write_reg(sstp_pkg::REG_SERIES, 20'($urandom_range(1, 1048575)));
            write_reg(sstp_pkg::REG_NOMINAL, 20'($urandom_range(1, 1048575)));
            write_reg(sstp_pkg::REG_BETA, 20'($urandom_range(1, 65535)));
            write_reg(sstp_pkg::REG_NOMTEMP, 20'($urandom_range(0, 15000)));
            write_reg(sstp_pkg::REG_PFULL, 20'($urandom_range(0, 65535)));
            write_reg(sstp_pkg::REG_PZERO, 20'($urandom_range(0, 65535)));
            drain();
            run_phase(20);
        end
        write_reg(sstp_pkg::REG_SERIES, 20'd10000);
        write_reg(sstp_pkg::REG_NOMINAL, 20'd10000);
        write_reg(sstp_pkg::REG_BETA, 20'd3950);
        write_reg(sstp_pkg::REG_NOMTEMP, 20'd2500);
        write_reg(sstp_pkg::REG_PFULL, 20'd10000);
        write_reg(sstp_pkg::REG_PZERO, 20'd0);
        drain();
        calm = 1;
        run_phase(30);

        if (errors == 0)
            $display("sensor_scan_thermistor_pressure regression: pass");
        else
            $display("sensor_scan_thermistor_pressure regression: fail");
        $finish;
    end
endmodule
